[hw/rtl/twct_pkg.sv]
package twct_pkg;

  localparam int COORD_W     = 32;
  localparam int NORM_W      = 16;
  localparam int MARGIN_W    = 21;
  localparam int NORM_FRAC_W = 14;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(6554);

  // normal times margin, margin taken as a non-negative signed value
  localparam int OFS_W  = NORM_W + MARGIN_W;
  // coordinates in units of 2^-30 plus offset
  localparam int PT_W   = COORD_W + NORM_FRAC_W + 1;
  localparam int DIFF_W = PT_W + 1;
  localparam int HALF_W = DIFF_W / 2;
  localparam int PROD_W = 2 * DIFF_W;

  localparam int NUM_PTS   = 6;
  localparam int NUM_LANES = 12;
  localparam int NUM_EDGES = 4;
  localparam int PIPE_LAT  = 7;

  typedef enum logic [2:0] {
    PT_F,
    PT_T,
    PT_AP,
    PT_AM,
    PT_BP,
    PT_BM
  } pt_idx_t;

  typedef logic [3:0] lane_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } crd_t;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
  } vec_t;

  // orientation lanes: sign of (q - p) x (r - p)
  localparam pt_idx_t LANE_P [NUM_LANES] = '{
    PT_F,  PT_F,  PT_F,  PT_F,
    PT_AP, PT_AP, PT_AM, PT_AM,
    PT_BP, PT_BP, PT_AP, PT_AP
  };
  localparam pt_idx_t LANE_Q [NUM_LANES] = '{
    PT_T,  PT_T,  PT_T,  PT_T,
    PT_BP, PT_BP, PT_BM, PT_BM,
    PT_BM, PT_BM, PT_AM, PT_AM
  };
  localparam pt_idx_t LANE_R [NUM_LANES] = '{
    PT_AP, PT_AM, PT_BP, PT_BM,
    PT_F,  PT_T,  PT_F,  PT_T,
    PT_F,  PT_T,  PT_F,  PT_T
  };

  // per edge: movement vs both edge ends, then edge vs both movement ends
  localparam lane_idx_t EDGE_LANE [NUM_EDGES][4] = '{
    '{4'd0, 4'd2, 4'd4,  4'd5},
    '{4'd1, 4'd3, 4'd6,  4'd7},
    '{4'd2, 4'd3, 4'd8,  4'd9},
    '{4'd0, 4'd1, 4'd10, 4'd11}
  };

endpackage

[hw/rtl/thick_wall_crossing_test_unit.sv]
// Thick wall crossing test. Each request carries a wall segment A-B, its
// normal n (Q2.14) and a movement segment F-T (Q16.16). The wall is widened
// by the margin register along +n and -n and out_hit reports whether the
// movement crosses or touches any edge of that rectangle;
// touching and collinear edges count as hits. The unit is a seven stage
// pipeline (margin offset, points, differences, partial products, products,
// orientation signs, hit) and takes a new request every clock, so busy stays
// low. Each request gives one result, shown for one cycle with out_valid;
// the receiver cannot stall it. Write cfg_wdata only while no request is
// in flight.
module thick_wall_crossing_test_unit
  import twct_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [MARGIN_W-1:0]        cfg_wdata,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [COORD_W-1:0]  in_wall_ax,
  input  logic signed [COORD_W-1:0]  in_wall_ay,
  input  logic signed [COORD_W-1:0]  in_wall_bx,
  input  logic signed [COORD_W-1:0]  in_wall_by,
  input  logic signed [NORM_W-1:0]   in_wall_nx,
  input  logic signed [NORM_W-1:0]   in_wall_ny,
  input  logic signed [COORD_W-1:0]  in_move_from_x,
  input  logic signed [COORD_W-1:0]  in_move_from_y,
  input  logic signed [COORD_W-1:0]  in_move_to_x,
  input  logic signed [COORD_W-1:0]  in_move_to_y,
  output logic                       out_valid,
  output logic                       out_hit
);

  function automatic logic signed [PT_W-1:0] scale_crd(input logic signed [COORD_W-1:0] c);
    logic signed [COORD_W+NORM_FRAC_W-1:0] s;
    s = $signed({c, NORM_FRAC_W'(0)});
    return PT_W'(s);
  endfunction

  logic [MARGIN_W-1:0] margin_r;
  logic [PIPE_LAT-1:0] vld_r;

  // stage 1: offsets and coordinates
  logic signed [OFS_W:0]   nx_ext, ny_ext, mg_ext;
  logic signed [OFS_W:0]   ox_full, oy_full;
  logic signed [OFS_W-1:0] ox_nxt, oy_nxt;
  logic signed [OFS_W-1:0] s1_ox_r, s1_oy_r;
  crd_t                    s1_a_r, s1_b_r, s1_f_r, s1_t_r;

  // stage 2: points
  point_t pts_nxt [NUM_PTS];
  point_t s2_pts_r [NUM_PTS];

  // stage 3: lane vectors
  vec_t s3_q_r [NUM_LANES];
  vec_t s3_r_r [NUM_LANES];

  // stage 4: partial products, index 0 is q.x*r.y and 1 is q.y*r.x
  logic signed [2*HALF_W-1:0] s4_hh_r [NUM_LANES][2];
  logic signed [2*HALF_W:0]   s4_hl_r [NUM_LANES][2];
  logic signed [2*HALF_W:0]   s4_lh_r [NUM_LANES][2];
  logic [2*HALF_W-1:0]        s4_ll_r [NUM_LANES][2];

  // stage 5: full products
  logic signed [PROD_W-1:0] s5_prod_r [NUM_LANES][2];

  // stage 6: orientation signs
  logic s6_neg_r  [NUM_LANES];
  logic s6_zero_r [NUM_LANES];

  // stage 7: result
  logic [NUM_EDGES-1:0] meet;
  logic                 hit_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RESET;
      vld_r    <= '0;
    end else begin
      if (cfg_we) begin
        margin_r <= cfg_wdata;
      end
      vld_r <= {vld_r[PIPE_LAT-2:0], start & ~busy};
    end
  end

  assign nx_ext  = (OFS_W+1)'(in_wall_nx);
  assign ny_ext  = (OFS_W+1)'(in_wall_ny);
  assign mg_ext  = $signed((OFS_W+1)'(margin_r));
  assign ox_full = nx_ext * mg_ext;
  assign oy_full = ny_ext * mg_ext;
  assign ox_nxt  = ox_full[OFS_W-1:0];
  assign oy_nxt  = oy_full[OFS_W-1:0];

  always_ff @(posedge clk) begin
    s1_ox_r  <= ox_nxt;
    s1_oy_r  <= oy_nxt;
    s1_a_r.x <= in_wall_ax;
    s1_a_r.y <= in_wall_ay;
    s1_b_r.x <= in_wall_bx;
    s1_b_r.y <= in_wall_by;
    s1_f_r.x <= in_move_from_x;
    s1_f_r.y <= in_move_from_y;
    s1_t_r.x <= in_move_to_x;
    s1_t_r.y <= in_move_to_y;
  end

  always_comb begin
    pts_nxt[PT_F].x  = scale_crd(s1_f_r.x);
    pts_nxt[PT_F].y  = scale_crd(s1_f_r.y);
    pts_nxt[PT_T].x  = scale_crd(s1_t_r.x);
    pts_nxt[PT_T].y  = scale_crd(s1_t_r.y);
    pts_nxt[PT_AP].x = scale_crd(s1_a_r.x) + PT_W'(s1_ox_r);
    pts_nxt[PT_AP].y = scale_crd(s1_a_r.y) + PT_W'(s1_oy_r);
    pts_nxt[PT_AM].x = scale_crd(s1_a_r.x) - PT_W'(s1_ox_r);
    pts_nxt[PT_AM].y = scale_crd(s1_a_r.y) - PT_W'(s1_oy_r);
    pts_nxt[PT_BP].x = scale_crd(s1_b_r.x) + PT_W'(s1_ox_r);
    pts_nxt[PT_BP].y = scale_crd(s1_b_r.y) + PT_W'(s1_oy_r);
    pts_nxt[PT_BM].x = scale_crd(s1_b_r.x) - PT_W'(s1_ox_r);
    pts_nxt[PT_BM].y = scale_crd(s1_b_r.y) - PT_W'(s1_oy_r);
  end

  always_ff @(posedge clk) begin
    s2_pts_r <= pts_nxt;
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    vec_t                     q_nxt, r_nxt;
    logic signed [PROD_W-1:0] d_nxt;

    assign q_nxt.x = DIFF_W'(s2_pts_r[LANE_Q[k]].x) - DIFF_W'(s2_pts_r[LANE_P[k]].x);
    assign q_nxt.y = DIFF_W'(s2_pts_r[LANE_Q[k]].y) - DIFF_W'(s2_pts_r[LANE_P[k]].y);
    assign r_nxt.x = DIFF_W'(s2_pts_r[LANE_R[k]].x) - DIFF_W'(s2_pts_r[LANE_P[k]].x);
    assign r_nxt.y = DIFF_W'(s2_pts_r[LANE_R[k]].y) - DIFF_W'(s2_pts_r[LANE_P[k]].y);

    always_ff @(posedge clk) begin
      s3_q_r[k] <= q_nxt;
      s3_r_r[k] <= r_nxt;
    end

    for (genvar j = 0; j < 2; j++) begin : g_mul
      logic signed [DIFF_W-1:0]   op_a, op_b;
      logic signed [HALF_W-1:0]   a_hi, b_hi;
      logic signed [HALF_W:0]     a_lo, b_lo;
      logic signed [2*HALF_W-1:0] hh_nxt;
      logic signed [2*HALF_W:0]   hl_nxt, lh_nxt;
      logic [2*HALF_W-1:0]        ll_nxt;
      logic [PROD_W-1:0]          prod_nxt;

      if (j == 0) begin : g_xy
        assign op_a = s3_q_r[k].x;
        assign op_b = s3_r_r[k].y;
      end else begin : g_yx
        assign op_a = s3_q_r[k].y;
        assign op_b = s3_r_r[k].x;
      end

      assign a_hi   = op_a[DIFF_W-1:HALF_W];
      assign b_hi   = op_b[DIFF_W-1:HALF_W];
      assign a_lo   = $signed({1'b0, op_a[HALF_W-1:0]});
      assign b_lo   = $signed({1'b0, op_b[HALF_W-1:0]});
      assign hh_nxt = a_hi * b_hi;
      assign hl_nxt = a_hi * b_lo;
      assign lh_nxt = a_lo * b_hi;
      assign ll_nxt = op_a[HALF_W-1:0] * op_b[HALF_W-1:0];

      always_ff @(posedge clk) begin
        s4_hh_r[k][j] <= hh_nxt;
        s4_hl_r[k][j] <= hl_nxt;
        s4_lh_r[k][j] <= lh_nxt;
        s4_ll_r[k][j] <= ll_nxt;
      end

      assign prod_nxt = (PROD_W'(s4_hh_r[k][j]) << (2*HALF_W))
                      + (PROD_W'(s4_hl_r[k][j]) << HALF_W)
                      + (PROD_W'(s4_lh_r[k][j]) << HALF_W)
                      + PROD_W'(s4_ll_r[k][j]);

      always_ff @(posedge clk) begin
        s5_prod_r[k][j] <= $signed(prod_nxt);
      end
    end

    assign d_nxt = s5_prod_r[k][0] - s5_prod_r[k][1];

    always_ff @(posedge clk) begin
      s6_neg_r[k]  <= d_nxt[PROD_W-1];
      s6_zero_r[k] <= (d_nxt == '0);
    end
  end

  // opposite sides or touching, for both segment pairs of an edge
  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
    assign meet[e] =
      (s6_zero_r[EDGE_LANE[e][0]] | s6_zero_r[EDGE_LANE[e][1]] |
       (s6_neg_r[EDGE_LANE[e][0]] ^ s6_neg_r[EDGE_LANE[e][1]])) &
      (s6_zero_r[EDGE_LANE[e][2]] | s6_zero_r[EDGE_LANE[e][3]] |
       (s6_neg_r[EDGE_LANE[e][2]] ^ s6_neg_r[EDGE_LANE[e][3]]));
  end

  always_ff @(posedge clk) begin
    hit_r <= |meet;
  end

  assign out_valid = vld_r[PIPE_LAT-1];
  assign out_hit   = hit_r;

`ifndef ASSERT_OFF
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && rst_n, PIPE_LAT))
    else $error("result without matching request");

  a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("request lost in pipeline");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vld_r[0]) |=> !busy)
    else $error("pipeline blocked requests");
`endif

endmodule

[dv/testbench.sv]
module testbench
  import twct_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int U        = 65536;
  localparam int CMAX     = 2147483647;
  localparam int CMIN     = -CMAX - 1;
  localparam int GAP_LONG = 40;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [NORM_W-1:0]  nx;
    logic signed [NORM_W-1:0]  ny;
    logic signed [COORD_W-1:0] fx;
    logic signed [COORD_W-1:0] fy;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
  } wall_req_t;

  // point in units of 2^-30
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
  } fpt_t;

  class hit_scoreboard;
    logic [MARGIN_W-1:0] margin;
    bit                  expected_hits[$];
    int                  errors;

    function new();
      margin = MARGIN_RESET;
      errors = 0;
    endfunction

    function void set_margin(logic [MARGIN_W-1:0] value);
      margin = value;
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction

    function int turn_sign(fpt_t p, fpt_t q, fpt_t r);
      logic signed [127:0] ux, uy, vx, vy, cr;
      ux = q.x - p.x;
      uy = q.y - p.y;
      vx = r.x - p.x;
      vy = r.y - p.y;
      cr = ux * vy - uy * vx;
      if (cr < 0) return -1;
      if (cr == 0) return 0;
      return 1;
    endfunction

    function bit segments_meet(fpt_t a, fpt_t b, fpt_t c, fpt_t d);
      return turn_sign(a, b, c) * turn_sign(a, b, d) <= 0 &&
             turn_sign(c, d, a) * turn_sign(c, d, b) <= 0;
    endfunction

    function bit predict_hit(wall_req_t r);
      logic signed [63:0] ox, oy;
      fpt_t ap, am, bp, bm, f, t;
      ox = 64'(r.nx) * $signed(64'(margin));
      oy = 64'(r.ny) * $signed(64'(margin));
      ap.x = 64'(r.ax) * 16384 + ox;
      ap.y = 64'(r.ay) * 16384 + oy;
      am.x = 64'(r.ax) * 16384 - ox;
      am.y = 64'(r.ay) * 16384 - oy;
      bp.x = 64'(r.bx) * 16384 + ox;
      bp.y = 64'(r.by) * 16384 + oy;
      bm.x = 64'(r.bx) * 16384 - ox;
      bm.y = 64'(r.by) * 16384 - oy;
      f.x  = 64'(r.fx) * 16384;
      f.y  = 64'(r.fy) * 16384;
      t.x  = 64'(r.tx) * 16384;
      t.y  = 64'(r.ty) * 16384;
      return segments_meet(f, t, ap, bp) || segments_meet(f, t, am, bm) ||
             segments_meet(f, t, bp, bm) || segments_meet(f, t, ap, am);
    endfunction

    function void note_request(wall_req_t r);
      expected_hits = {expected_hits, predict_hit(r)};
    endfunction

    function void check_result(bit hit);
      bit exp_hit;
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual hit=%0b", $time, hit);
        errors++;
      end else begin
        exp_hit = expected_hits.pop_front();
        if (exp_hit !== hit) begin
          $display("%0t: hit mismatch: expected %0b, actual %0b", $time, exp_hit, hit);
          errors++;
        end
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [MARGIN_W-1:0]       cfg_wdata = '0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] in_wall_ax = '0;
  logic signed [COORD_W-1:0] in_wall_ay = '0;
  logic signed [COORD_W-1:0] in_wall_bx = '0;
  logic signed [COORD_W-1:0] in_wall_by = '0;
  logic signed [NORM_W-1:0]  in_wall_nx = '0;
  logic signed [NORM_W-1:0]  in_wall_ny = '0;
  logic signed [COORD_W-1:0] in_move_from_x = '0;
  logic signed [COORD_W-1:0] in_move_from_y = '0;
  logic signed [COORD_W-1:0] in_move_to_x = '0;
  logic signed [COORD_W-1:0] in_move_to_y = '0;
  logic                      out_valid;
  logic                      out_hit;

  hit_scoreboard sb = new();
  bit            no_idle = 1'b0;
  wall_req_t     seen_req;

  thick_wall_crossing_test_unit u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      seen_req = '{ax: in_wall_ax, ay: in_wall_ay, bx: in_wall_bx, by: in_wall_by,
                   nx: in_wall_nx, ny: in_wall_ny,
                   fx: in_move_from_x, fy: in_move_from_y,
                   tx: in_move_to_x, ty: in_move_to_y};
      sb.note_request(seen_req);
    end
    if (rst_n && out_valid) begin
      sb.check_result(out_hit);
    end
  end

  function automatic wall_req_t make_req(int ax, int ay, int bx, int by, int nx, int ny,
                                         int fx, int fy, int tx, int ty);
    wall_req_t r;
    r.ax = ax;
    r.ay = ay;
    r.bx = bx;
    r.by = by;
    r.nx = 16'(nx);
    r.ny = 16'(ny);
    r.fx = fx;
    r.fy = fy;
    r.tx = tx;
    r.ty = ty;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, GAP_LONG);
  endfunction

  function automatic int near(int c, int span);
    return c + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // random edge, the base line, or a grid point around it
  function automatic int axis_coord(int base, int g, int e1, int e2);
    case ($urandom_range(0, 4))
      0: return e1;
      1: return e2;
      2: return base;
      default: return base + (int'($urandom_range(0, 24)) - 12) * g;
    endcase
  endfunction

  function automatic wall_req_t rand_noise();
    wall_req_t r;
    r.ax = $urandom;
    r.ay = $urandom;
    r.bx = $urandom;
    r.by = $urandom;
    r.nx = 16'($urandom);
    r.ny = 16'($urandom);
    r.fx = $urandom;
    r.fy = $urandom;
    r.tx = $urandom;
    r.ty = $urandom;
    return r;
  endfunction

  function automatic wall_req_t rand_local();
    int        span, mspan, cx, cy;
    real       dx, dy, len;
    wall_req_t r;
    span  = 1 << $urandom_range(4, 26);
    mspan = span << $urandom_range(0, 2);
    cx    = int'($urandom) >>> 2;
    cy    = int'($urandom) >>> 2;
    r.ax  = near(cx, span);
    r.ay  = near(cy, span);
    r.bx  = near(cx, span);
    r.by  = near(cy, span);
    r.fx  = near(cx, mspan);
    r.fy  = near(cy, mspan);
    r.tx  = near(cx, mspan);
    r.ty  = near(cy, mspan);
    dx    = real'(longint'(r.bx) - longint'(r.ax));
    dy    = real'(longint'(r.by) - longint'(r.ay));
    len   = $sqrt(dx * dx + dy * dy);
    if (len == 0.0) begin
      r.nx = 16'(int'($urandom_range(0, 32768)) - 16384);
      r.ny = 16'(int'($urandom_range(0, 32768)) - 16384);
    end else begin
      r.nx = 16'($rtoi(-dy / len * 16384.0));
      r.ny = 16'($rtoi(dx / len * 16384.0));
    end
    if ($urandom_range(0, 1)) begin
      r.nx = -r.nx;
      r.ny = -r.ny;
    end
    return r;
  endfunction

  // axis-aligned wall so edges land exactly on the coordinate grid
  function automatic wall_req_t rand_axis(int m);
    int        g, u0, v0, lo, hi, fu, fv, tu, tv, ns;
    wall_req_t r;
    g  = 1 << $urandom_range(0, 16);
    u0 = int'($urandom) >>> 2;
    v0 = int'($urandom) >>> 2;
    lo = u0 + (int'($urandom_range(0, 16)) - 8) * g;
    hi = u0 + (int'($urandom_range(0, 16)) - 8) * g;
    fu = axis_coord(u0, g, lo, hi);
    tu = axis_coord(u0, g, lo, hi);
    fv = axis_coord(v0, g, v0 + m, v0 - m);
    tv = axis_coord(v0, g, v0 + m, v0 - m);
    ns = $urandom_range(0, 1) ? 16384 : -16384;
    if ($urandom_range(0, 1)) begin
      r = make_req(lo, v0, hi, v0, 0, ns, fu, fv, tu, tv);
    end else begin
      r = make_req(v0, lo, v0, hi, ns, 0, fv, fu, tv, tu);
    end
    return r;
  endfunction

  function automatic wall_req_t rand_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return rand_noise();
    if (r < 35) return rand_axis(int'(sb.margin));
    return rand_local();
  endfunction

  task automatic send_request(input wall_req_t r, input int gap);
    start          <= 1'b1;
    in_wall_ax     <= r.ax;
    in_wall_ay     <= r.ay;
    in_wall_bx     <= r.bx;
    in_wall_by     <= r.by;
    in_wall_nx     <= r.nx;
    in_wall_ny     <= r.ny;
    in_move_from_x <= r.fx;
    in_move_from_y <= r.fy;
    in_move_to_x   <= r.tx;
    in_move_to_y   <= r.ty;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_margin(input logic [MARGIN_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_margin(value);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_request(rand_request(), pick_gap());
    end
    no_idle = 1'b0;
  endtask

  // wall (0,0)-(10,0) with unit normal along y, margin 1.0
  task automatic run_directed();
    wall_req_t dir_reqs[$];
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 0, 16384, 5*U, -5*U, 5*U, 5*U)};
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 0, 16384, 20*U, -5*U, 20*U, 5*U)};
    // fully inside the rectangle
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 0, 16384, 2*U, U/2, 8*U, -U/2)};
    // touching
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 0, 16384, 5*U, U, 5*U, 5*U)};
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 0, 16384, 10*U, U, 12*U, 3*U)};
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 0, 16384, 0, -U, -2*U, -3*U)};
    // collinear, overlapping and disjoint
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 0, 16384, -5*U, U, 15*U, U)};
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 0, 16384, 20*U, U, 30*U, U)};
    // zero-length movement
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 0, 16384, 20*U, U, 20*U, U)};
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 0, 16384, 5*U, 3*U, 5*U, 3*U)};
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 0, 16384, 5*U, 0, 5*U, 0)};
    // end caps
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 0, 16384, -3*U, 0, 3*U, 0)};
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 0, 16384, -3*U, 0, -U/2, 0)};
    // normal not of unit length
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 0, 32767, 5*U, 3*U, 5*U, 19*U/10)};
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, -32768, 0, 5*U, 3*U, 5*U, -3*U)};
    dir_reqs = {dir_reqs, make_req(0, 0, 10*U, 0, 3, -5, 5*U, 3*U, 5*U, U/2)};
    // zero-length wall
    dir_reqs = {dir_reqs, make_req(0, 0, 0, 0, 0, 16384, -U, 0, U, 0)};
    dir_reqs = {dir_reqs, make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    // field extremes
    dir_reqs = {dir_reqs, make_req(CMAX, CMAX, CMAX, CMAX, 32767, 16384,
                                   CMAX, CMAX, CMAX, CMAX)};
    dir_reqs = {dir_reqs, make_req(CMIN, CMIN, CMIN, CMIN, -32768, -16384,
                                   CMIN, CMIN, CMIN, CMIN)};
    dir_reqs = {dir_reqs, make_req(CMAX, CMIN, CMIN, CMAX, -32768, 32767,
                                   CMIN, CMIN, CMAX, CMAX)};
    dir_reqs = {dir_reqs, make_req(CMIN, CMIN, CMAX, CMIN, 0, 16384, 0, CMAX, 0, CMIN)};
    dir_reqs = {dir_reqs, make_req(CMIN, CMAX, CMAX, CMAX, -16384, 16384,
                                   CMAX, CMIN, CMIN, CMIN)};
    foreach (dir_reqs[i]) send_request(dir_reqs[i], pick_gap());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    run_random(250);
    write_margin(MARGIN_W'(U));
    run_directed();
    write_margin('0);
    run_random(290);
    write_margin(MARGIN_W'(1048576));
    run_random(290);
    write_margin('1);
    run_random(290);
    write_margin(MARGIN_W'(1));
    run_random(290);
    write_margin(MARGIN_W'($urandom));
    run_random(290);
    write_margin(MARGIN_W'($urandom_range(0, 131072)));
    run_random(290);
    drain();
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
